/* design/zbps_pkg.sv */
// Shared constants, codes and types for the z-buffered point shader.
// Used by zbuffer_point_shader_top; has no dependencies.
package zbps_pkg;

  // Screen geometry
  localparam int HALF_WIDTH  = 80;
  localparam int HALF_HEIGHT = 25;
  localparam int SCR_W       = 2 * HALF_WIDTH + 1;
  localparam int SCR_H       = 2 * HALF_HEIGHT + 1;
  localparam int STORE_DEPTH = SCR_W * SCR_H;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int COL_W   = 8;
  localparam int ROW_W   = 6;
  localparam int SHADE_W = 4;
  localparam int DEPTH_W = 16;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 3;
  localparam int IN_W    = 112;
  localparam int OUT_W   = 24;

  localparam logic [SHADE_W-1:0] SHADE_NONE = 4'd15;
  localparam logic [3:0]         SHADE_MAX  = 4'd9;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_REJECT = 3'd0;
  localparam logic [STAT_W-1:0] ST_HIDDEN = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNLIT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DRAWN  = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ   = 3'd4;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FOCAL = 3'd0;
  localparam logic [CIDX_W-1:0] REG_NEAR  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FAR   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LX    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_LY    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_LZ    = 3'd5;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MUL_X, S_MUL_Y, S_CHECK, S_DIV, S_PROJ, S_DEPTH_WAIT,
    S_DEPTH, S_DOT_X, S_DOT_Y, S_DOT_Z, S_SQ_X, S_SQ_Y, S_SQ_Z, S_LIT,
    S_DD_LL, S_DD_HL, S_DD_HH, S_LIM_A, S_LIM_B, S_SHADE, S_WRITE,
    S_RD_WAIT, S_RD_DATA, S_OUT
  } state_t;

endpackage

/* design/zbps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module zbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/zbuffer_point_shader_top.sv */
// Z-buffered point plotter with Lambert shading: top level.
// Depends on zbps_pkg and zbps_ram.
//
// After reset the block sweeps its depth and shade memories, one entry per
// cycle over all 8211 entries, and accepts no request until that is done.
// A plot request then runs two products on the shared 17x17 multiplier for
// the frustum test, a seven-step shift-subtract divide for the projection,
// a read-modify-write of the depth memory, nine more multiplier steps for
// the Lambert term and up to ten steps of the shade search. A rejected or
// hidden point finishes early, and a read-and-clear request uses none of
// these steps. One request is worked on at a time; a finished result waits
// in the output register while the next request is taken.
module zbuffer_point_shader_top (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream. tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
  // read_column, read_row (lowest bits first). tuser: func.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [zbps_pkg::IN_W-1:0]     s_axis_tdata,
  input  logic                          s_axis_tuser,
  // Output stream. tdata: column, row, shade_code (lowest bits first).
  // tuser: status.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [zbps_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic [zbps_pkg::STAT_W-1:0]   m_axis_tuser,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [zbps_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [zbps_pkg::CFG_W-1:0]    cfg_data
);
  import zbps_pkg::*;

  state_t state, state_next;

  // Configuration registers
  logic [9:0]         focal;
  logic [10:0]        near_d, far_d;
  logic signed [15:0] lx, ly, lz;

  // Request registers
  logic signed [15:0] px, py, pz, nx, ny, nz;

  // Datapath registers
  logic [25:0]        prod_x, prod_y, rem_x, rem_y;
  logic [6:0]         q_x, q_y;
  logic [2:0]         div_cnt;
  logic signed [33:0] d_acc;
  logic [33:0]        s_acc;
  logic [63:0]        dd;
  logic [67:0]        dd9;
  logic [43:0]        lim, v, t;
  logic [3:0]         k;
  logic [ADDR_W-1:0]  addr, clr_cnt;
  logic [STAT_W-1:0]  res_status;
  logic [COL_W-1:0]   res_col;
  logic [ROW_W-1:0]   res_row;
  logic [SHADE_W-1:0] res_shade;

  // Output register
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [COL_W-1:0]   out_col;
  logic [ROW_W-1:0]   out_row;
  logic [SHADE_W-1:0] out_shade;

  // Memory ports
  logic               mem_we_d, mem_we_s;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DEPTH_W-1:0] mem_wdata_d, depth_rdata;
  logic [SHADE_W-1:0] mem_wdata_s, shade_rdata;

  // Shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;

  // Combinational helpers
  logic               accept, out_free, fits, lit_ok, depth_win, shade_step;
  logic [16:0]        ax, ay;
  logic [COL_W-1:0]   in_col, proj_col;
  logic [ROW_W-1:0]   in_row, proj_row;
  logic [25:0]        dz;
  logic [43:0]        v_sum;

  assign prod     = mul_a * mul_b;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign in_col   = s_axis_tdata[103:96];
  assign in_row   = s_axis_tdata[109:104];
  assign ax       = px[15] ? 17'(-{px[15], px}) : {1'b0, px};
  assign ay       = py[15] ? 17'(-{py[15], py}) : {1'b0, py};
  assign dz       = 26'(pz[14:0]) << div_cnt;
  assign v_sum    = v + t;
  assign lit_ok   = (d_acc > 34'sd0) && (s_acc != 34'd0);
  assign depth_win  = {1'b0, pz[14:0]} < depth_rdata;
  assign shade_step = (k < SHADE_MAX) && (v_sum <= lim);

  // Depth range and frustum test on the two registered products
  assign fits = (pz > 16'sd0) &&
                ({1'b0, pz} >= {2'b0, near_d, 4'b0}) &&
                ({1'b0, pz} <= {2'b0, far_d, 4'b0}) &&
                (prod_x <= 26'(pz[14:0]) * 26'(HALF_WIDTH + 1)) &&
                (prod_y <= 26'(pz[14:0]) * 26'(HALF_HEIGHT + 1));

  // Projected pixel, with truncation toward zero
  assign proj_col = px[15] ? COL_W'(HALF_WIDTH) - COL_W'(q_x)
                           : COL_W'(HALF_WIDTH) + COL_W'(q_x);
  assign proj_row = py[15] ? ROW_W'(HALF_HEIGHT) - ROW_W'(q_y)
                           : ROW_W'(HALF_HEIGHT) + ROW_W'(q_y);

  zbps_ram #(.WIDTH(DEPTH_W), .DEPTH(STORE_DEPTH)) u_depth_ram (
    .clk(clk), .we(mem_we_d), .waddr(mem_waddr), .wdata(mem_wdata_d),
    .raddr(addr), .rdata(depth_rdata)
  );

  zbps_ram #(.WIDTH(SHADE_W), .DEPTH(STORE_DEPTH)) u_shade_ram (
    .clk(clk), .we(mem_we_s), .waddr(mem_waddr), .wdata(mem_wdata_s),
    .raddr(addr), .rdata(shade_rdata)
  );

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:      if (clr_cnt == ADDR_W'(STORE_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (!s_axis_tuser) begin
            state_next = S_MUL_X;
          end else if (in_col >= COL_W'(SCR_W) || in_row >= ROW_W'(SCR_H)) begin
            state_next = S_OUT;
          end else begin
            state_next = S_RD_WAIT;
          end
        end
      end
      S_MUL_X:      state_next = S_MUL_Y;
      S_MUL_Y:      state_next = S_CHECK;
      S_CHECK:      state_next = fits ? S_DIV : S_OUT;
      S_DIV:        if (div_cnt == 3'd0) state_next = S_PROJ;
      S_PROJ: begin
        if (q_x > 7'(HALF_WIDTH) || q_y > 7'(HALF_HEIGHT)) state_next = S_OUT;
        else state_next = S_DEPTH_WAIT;
      end
      S_DEPTH_WAIT: state_next = S_DEPTH;
      S_DEPTH:      state_next = depth_win ? S_DOT_X : S_OUT;
      S_DOT_X:      state_next = S_DOT_Y;
      S_DOT_Y:      state_next = S_DOT_Z;
      S_DOT_Z:      state_next = S_SQ_X;
      S_SQ_X:       state_next = S_SQ_Y;
      S_SQ_Y:       state_next = S_SQ_Z;
      S_SQ_Z:       state_next = S_LIT;
      S_LIT:        state_next = lit_ok ? S_DD_LL : S_OUT;
      S_DD_LL:      state_next = S_DD_HL;
      S_DD_HL:      state_next = S_DD_HH;
      S_DD_HH:      state_next = S_LIM_A;
      S_LIM_A:      state_next = S_LIM_B;
      S_LIM_B:      state_next = S_SHADE;
      S_SHADE:      if (!shade_step) state_next = S_WRITE;
      S_WRITE:      state_next = S_OUT;
      S_RD_WAIT:    state_next = S_RD_DATA;
      S_RD_DATA:    state_next = S_OUT;
      S_OUT:        if (out_free) state_next = S_IDLE;
      default:      state_next = S_CLEAR;
    endcase
  end

  // Multiplier operands and memory controls
  always_comb begin
    mul_a       = 17'sd0;
    mul_b       = 17'sd0;
    mem_we_d    = 1'b0;
    mem_we_s    = 1'b0;
    mem_waddr   = addr;
    mem_wdata_d = {1'b0, pz[14:0]};
    mem_wdata_s = k;
    s_axis_tready = (state == S_IDLE);
    unique case (state)
      S_CLEAR: begin
        mem_we_d    = 1'b1;
        mem_we_s    = 1'b1;
        mem_waddr   = clr_cnt;
        mem_wdata_d = '1;
        mem_wdata_s = SHADE_NONE;
      end
      S_MUL_X: begin
        mul_a = signed'(ax);
        mul_b = signed'({7'b0, focal});
      end
      S_MUL_Y: begin
        mul_a = signed'(ay);
        mul_b = signed'({7'b0, focal});
      end
      S_DEPTH:  mem_we_d = depth_win;
      S_DOT_X: begin
        mul_a = 17'(lx);
        mul_b = 17'(nx);
      end
      S_DOT_Y: begin
        mul_a = 17'(ly);
        mul_b = 17'(ny);
      end
      S_DOT_Z: begin
        mul_a = 17'(lz);
        mul_b = 17'(nz);
      end
      S_SQ_X: begin
        mul_a = 17'(nx);
        mul_b = 17'(nx);
      end
      S_SQ_Y: begin
        mul_a = 17'(ny);
        mul_b = 17'(ny);
      end
      S_SQ_Z: begin
        mul_a = 17'(nz);
        mul_b = 17'(nz);
      end
      S_DD_LL: begin
        mul_a = signed'({1'b0, d_acc[15:0]});
        mul_b = signed'({1'b0, d_acc[15:0]});
      end
      S_DD_HL: begin
        mul_a = signed'({1'b0, d_acc[31:16]});
        mul_b = signed'({1'b0, d_acc[15:0]});
      end
      S_DD_HH: begin
        mul_a = signed'({1'b0, d_acc[31:16]});
        mul_b = signed'({1'b0, d_acc[31:16]});
      end
      S_WRITE:   mem_we_s = 1'b1;
      S_RD_DATA: begin
        mem_we_s    = 1'b1;
        mem_wdata_s = SHADE_NONE;
      end
      default: ;
    endcase
  end

  // Control registers: state, clearing counter, output valid, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      focal     <= 10'd25;
      near_d    <= 11'd5;
      far_d     <= 11'd500;
      lx        <= 16'sd0;
      ly        <= 16'sd0;
      lz        <= 16'sd16384;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FOCAL: focal  <= cfg_data[9:0];
          REG_NEAR:  near_d <= cfg_data[10:0];
          REG_FAR:   far_d  <= cfg_data[10:0];
          REG_LX:    lx     <= signed'(cfg_data);
          REG_LY:    ly     <= signed'(cfg_data);
          REG_LZ:    lz     <= signed'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        px         <= signed'(s_axis_tdata[15:0]);
        py         <= signed'(s_axis_tdata[31:16]);
        pz         <= signed'(s_axis_tdata[47:32]);
        nx         <= signed'(s_axis_tdata[63:48]);
        ny         <= signed'(s_axis_tdata[79:64]);
        nz         <= signed'(s_axis_tdata[95:80]);
        addr       <= ADDR_W'(in_col) * ADDR_W'(SCR_H) + ADDR_W'(in_row);
        res_status <= s_axis_tuser ? ST_READ : ST_REJECT;
        res_col    <= s_axis_tuser ? in_col : '0;
        res_row    <= s_axis_tuser ? in_row : '0;
        res_shade  <= SHADE_NONE;
      end
      S_MUL_X: prod_x <= prod[25:0];
      S_MUL_Y: prod_y <= prod[25:0];
      S_CHECK: begin
        rem_x   <= prod_x;
        rem_y   <= prod_y;
        q_x     <= '0;
        q_y     <= '0;
        div_cnt <= 3'd6;
      end
      // One quotient bit per cycle for each axis
      S_DIV: begin
        if (rem_x >= dz) begin
          rem_x        <= rem_x - dz;
          q_x[div_cnt] <= 1'b1;
        end
        if (rem_y >= dz) begin
          rem_y        <= rem_y - dz;
          q_y[div_cnt] <= 1'b1;
        end
        div_cnt <= div_cnt - 1'b1;
      end
      // An off-screen projection keeps the rejected pixel at zero
      S_PROJ: begin
        if (q_x <= 7'(HALF_WIDTH) && q_y <= 7'(HALF_HEIGHT)) begin
          addr    <= ADDR_W'(proj_col) * ADDR_W'(SCR_H) + ADDR_W'(proj_row);
          res_col <= proj_col;
          res_row <= proj_row;
        end
      end
      S_DEPTH: res_status <= depth_win ? ST_UNLIT : ST_HIDDEN;
      S_DOT_X: d_acc <= prod;
      S_DOT_Y: d_acc <= d_acc + prod;
      S_DOT_Z: d_acc <= d_acc + prod;
      S_SQ_X:  s_acc <= unsigned'(prod);
      S_SQ_Y:  s_acc <= s_acc + unsigned'(prod);
      S_SQ_Z:  s_acc <= s_acc + unsigned'(prod);
      // Square of the dot product from three 16-bit partial products
      S_DD_LL: dd <= 64'(prod[31:0]);
      S_DD_HL: dd <= dd + (64'(prod[31:0]) << 17);
      S_DD_HH: dd <= dd + (64'(prod[31:0]) << 32);
      // Limit is floor(100*dd / 2^28) = floor(25*dd / 2^26)
      S_LIM_A: dd9 <= 68'({dd, 3'b0}) + 68'(dd);
      S_LIM_B: begin
        lim <= 44'((69'({dd, 4'b0}) + 69'(dd9)) >> 26);
        v   <= '0;
        t   <= 44'(s_acc[31:0]);
        k   <= '0;
      end
      // Grow k while k*k*S stays within the limit, using odd-step increments
      S_SHADE: begin
        if (shade_step) begin
          v <= v_sum;
          t <= t + 44'({s_acc[31:0], 1'b0});
          k <= k + 1'b1;
        end
      end
      S_WRITE: begin
        res_status <= ST_DRAWN;
        res_shade  <= k;
      end
      S_RD_DATA: res_shade <= shade_rdata;
      default: ;
    endcase
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_status <= res_status;
      out_col    <= res_col;
      out_row    <= res_row;
      out_shade  <= res_shade;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {6'b0, out_shade, out_row, out_col};

endmodule
